// ----- hw/rtl/sid_pkg.sv -----
package sid_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  typedef logic [DataWidth-1:0] data_t;

  localparam data_t DwSign = {1'b1, {(DataWidth - 1){1'b0}}};
  localparam data_t DwMask = {DataWidth{1'b1}};

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_OVERFLOW,
    KIND_DIV_ZERO
  } kind_e;

  // One classified operation as it travels from the front to the back.
  typedef struct packed {
    kind_e kind;
    logic  neg;
    data_t mag_a;
    data_t mag_b;
  } op_t;

endpackage

// ----- hw/rtl/signed_int32_divider.sv -----
// Signed integer divider with per-operation flags.
//
// Command channel: drive dividend_i and divisor_i with start_i high. The
// transaction is taken at the rising edge where start_i is high and busy_o
// is low. A new transaction may be issued every cycle.
// Result channel: valid_o is high for exactly one cycle per transaction and
// qualifies quotient_o and the four flags. Results come out in issue order.
// The receiver cannot stall the result channel.
//
// From the accepting edge to valid_o the operation passes the classify
// register, the queue, the stage-0 register, then one restoring subtract
// stage per quotient bit and a final register that applies the sign and
// selects the special values. Throughput is one transaction per cycle; the
// back end never stalls, so busy_o only rises if the queue were to fill.
//
// Reset clears all valid bits and the queue; transactions in flight are
// dropped and no result is produced for them.
module signed_int32_divider import sid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  data_t dividend_i,
  input  data_t divisor_i,
  output logic  busy_o,
  output logic  valid_o,
  output data_t quotient_o,
  output logic  overflow_flag_o,
  output logic  sign_flag_o,
  output logic  div_by_zero_flag_o,
  output logic  zero_flag_o
);

  logic push;
  op_t  push_op;
  logic queue_full;
  logic queue_empty;
  op_t  head_op;
  logic pop;

  sid_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .dividend_i   (dividend_i),
    .divisor_i    (divisor_i),
    .busy_o       (busy_o),
    .op_valid_o   (push),
    .op_o         (push_op),
    .queue_full_i (queue_full)
  );

  sid_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (queue_full),
    .pop_i   (pop),
    .empty_o (queue_empty),
    .data_o  (head_op)
  );

  // The divider pipeline advances every cycle, so the head is taken at once.
  assign pop = !queue_empty;

  sid_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_valid_i         (pop),
    .op_i               (head_op),
    .valid_o            (valid_o),
    .quotient_o         (quotient_o),
    .overflow_flag_o    (overflow_flag_o),
    .sign_flag_o        (sign_flag_o),
    .div_by_zero_flag_o (div_by_zero_flag_o),
    .zero_flag_o        (zero_flag_o)
  );

endmodule

// ----- hw/rtl/sid_front.sv -----
module sid_front import sid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  data_t dividend_i,
  input  data_t divisor_i,
  output logic  busy_o,
  output logic  op_valid_o,
  output op_t   op_o,
  input  logic  queue_full_i
);

  logic  valid_q, valid_d;
  op_t   op_q, op_d;
  logic  accept;
  logic  push;
  logic  a_neg, b_neg;

  assign busy_o     = valid_q && queue_full_i;
  assign accept     = start_i && !busy_o;
  assign push       = valid_q && !queue_full_i;
  assign op_valid_o = push;
  assign op_o       = op_q;

  assign a_neg = dividend_i[DataWidth-1];
  assign b_neg = divisor_i[DataWidth-1];

  always_comb begin
    op_d.neg   = a_neg ^ b_neg;
    op_d.mag_a = a_neg ? (~dividend_i + data_t'(1)) : dividend_i;
    op_d.mag_b = b_neg ? (~divisor_i + data_t'(1)) : divisor_i;
    if ((dividend_i == DwSign) && (divisor_i == DwMask)) begin
      op_d.kind = KIND_OVERFLOW;
    end else if (divisor_i == '0) begin
      op_d.kind = KIND_DIV_ZERO;
    end else begin
      op_d.kind = KIND_NORMAL;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

endmodule

// ----- hw/rtl/sid_queue.sv -----
module sid_queue import sid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  data_o
);

  op_t                  mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [QueuePtrW-1:0] next_ptr(input logic [QueuePtrW-1:0] ptr);
    logic [QueuePtrW-1:0] res;
    if (ptr == QueuePtrW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = ptr + QueuePtrW'(1);
    end
    return res;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  cnt_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue count exceeds depth");

  cnt_track_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + QueueCntW'(1)))
    else $error("queue count did not follow a lone push");

  ptr_gap_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == QueueCntW'(QueueDepth)) || (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ----- hw/rtl/sid_back.sv -----
module sid_back import sid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  op_valid_i,
  input  op_t   op_i,
  output logic  valid_o,
  output data_t quotient_o,
  output logic  overflow_flag_o,
  output logic  sign_flag_o,
  output logic  div_by_zero_flag_o,
  output logic  zero_flag_o
);

  // Stage 0 holds the operation taken from the queue; stages 1 to DataWidth
  // each resolve one quotient bit, most significant first.
  logic  vld_q  [DataWidth+1];
  data_t rem_q  [DataWidth+1];
  data_t aq_q   [DataWidth+1];
  data_t b_q    [DataWidth+1];
  kind_e kind_q [DataWidth+1];
  logic  neg_q  [DataWidth+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= op_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i) begin
      rem_q[0]  <= '0;
      aq_q[0]   <= op_i.mag_a;
      b_q[0]    <= op_i.mag_b;
      kind_q[0] <= op_i.kind;
      neg_q[0]  <= op_i.neg;
    end
  end

  for (genvar i = 1; i <= DataWidth; i++) begin : g_stage
    data_t trial;
    logic  ge;

    // The partial remainder stays below the divisor, so its top bit is free.
    assign trial = {rem_q[i-1][DataWidth-2:0], aq_q[i-1][DataWidth-1]};
    assign ge    = (trial >= b_q[i-1]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[i-1]) begin
        rem_q[i]  <= ge ? (trial - b_q[i-1]) : trial;
        aq_q[i]   <= {aq_q[i-1][DataWidth-2:0], ge};
        b_q[i]    <= b_q[i-1];
        kind_q[i] <= kind_q[i-1];
        neg_q[i]  <= neg_q[i-1];
      end
    end
  end

  data_t mq;
  data_t q_d;
  logic  ovf_d, sgn_d, dz_d, zf_d;
  logic  valid_q;
  data_t q_q;
  logic  ovf_q, sgn_q, dz_q, zf_q;

  assign mq = aq_q[DataWidth];

  always_comb begin
    q_d   = '0;
    ovf_d = 1'b0;
    sgn_d = 1'b0;
    dz_d  = 1'b0;
    zf_d  = 1'b0;
    unique case (kind_q[DataWidth])
      KIND_OVERFLOW: begin
        q_d   = DwSign;
        ovf_d = 1'b1;
        sgn_d = 1'b1;
      end
      KIND_DIV_ZERO: begin
        q_d   = DwMask;
        dz_d  = 1'b1;
        sgn_d = 1'b1;
      end
      default: begin
        if (mq == '0) begin
          zf_d = 1'b1;
        end else if (neg_q[DataWidth]) begin
          q_d   = ~mq + data_t'(1);
          sgn_d = 1'b1;
        end else begin
          q_d = mq;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[DataWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[DataWidth]) begin
      q_q   <= q_d;
      ovf_q <= ovf_d;
      sgn_q <= sgn_d;
      dz_q  <= dz_d;
      zf_q  <= zf_d;
    end
  end

  assign valid_o            = valid_q;
  assign quotient_o         = q_q;
  assign overflow_flag_o    = ovf_q;
  assign sign_flag_o        = sgn_q;
  assign div_by_zero_flag_o = dz_q;
  assign zero_flag_o        = zf_q;

  out_follows_pipe_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(vld_q[DataWidth]))
    else $error("result strobe without an operation in the last stage");

  ovf_flags_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ovf_q) |-> (sgn_q && !dz_q && !zf_q && (q_q == DwSign)))
    else $error("overflow result has wrong flags or value");

  dz_flags_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && dz_q) |-> (sgn_q && !ovf_q && !zf_q && (q_q == DwMask)))
    else $error("divide-by-zero result has wrong flags or value");

  zero_flags_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && zf_q) |-> ((q_q == '0) && !sgn_q && !ovf_q && !dz_q))
    else $error("zero quotient has wrong flags");

endmodule
